// ----- rtl/ctp_pkg.sv -----
`timescale 1ns / 1ps

package ctp_pkg;

  // field being parsed
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_LAT  = 2'd1,
    MODE_LON  = 2'd2
  } mode_t;

  // ascii codes
  localparam logic [7:0] CHAR_N    = 8'h4E;
  localparam logic [7:0] CHAR_S    = 8'h53;
  localparam logic [7:0] CHAR_E    = 8'h45;
  localparam logic [7:0] CHAR_W    = 8'h57;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_NINE = 8'd57;

  // degree digit counts per field
  localparam logic [1:0] LAT_DEG_CHARS = 2'd2;
  localparam logic [1:0] LON_DEG_CHARS = 2'd3;

  // output scale: millionths of a degree
  localparam int         MICRO_DIGITS = 6;
  localparam int         FRAC_W       = 20;
  localparam int         DEG_W        = 10;
  localparam int         COORD_W      = 31;
  localparam logic [COORD_W-1:0] MICRO_SCALE = 31'd1000000;

  // weight of a fraction digit at a given position, in millionths
  function automatic logic [FRAC_W-1:0] digit_weight(input logic [3:0] d,
                                                     input logic [2:0] pos);
    logic [FRAC_W-1:0] dw;
    dw = FRAC_W'(d);
    case (pos)
      3'd0:    digit_weight = FRAC_W'(dw * 20'd100000);
      3'd1:    digit_weight = FRAC_W'(dw * 20'd10000);
      3'd2:    digit_weight = FRAC_W'(dw * 20'd1000);
      3'd3:    digit_weight = FRAC_W'(dw * 20'd100);
      3'd4:    digit_weight = FRAC_W'(dw * 20'd10);
      3'd5:    digit_weight = dw;
      default: digit_weight = '0;
    endcase
  endfunction

endpackage

// ----- rtl/ctp_byte_if.sv -----
`timescale 1ns / 1ps

interface ctp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/ctp_coord_if.sv -----
`timescale 1ns / 1ps

interface ctp_coord_if;
  logic               valid;
  logic               ready;
  logic               is_longitude;
  logic signed [30:0] coordinate_micro;
  logic               bad_text;

  modport source (output valid, output is_longitude, output coordinate_micro,
                  output bad_text, input ready);
  modport sink   (input valid, input is_longitude, input coordinate_micro,
                  input bad_text, output ready);
endinterface

// ----- rtl/coordinate_text_parser.sv -----
`timescale 1ns / 1ps
// A closing letter's result passes the input byte register, then the result register.
// Throughput: one byte per cycle, but a closing byte waits while the result is stalled;
//   fraction digits are weighted as they arrive, so a field close needs only one
//   constant multiply, an add and a negate.
// Reset (rst, synchronous, active high) clears the handshake and parser state.

module coordinate_text_parser #(
  parameter int FRAC_DIGITS = 6
) (
  input  logic         clk,
  input  logic         rst,
  ctp_byte_if.sink     rx,
  ctp_coord_if.source  coord
);

  localparam int KEPT  = (FRAC_DIGITS > 9) ? 9 : FRAC_DIGITS;
  localparam int CNT_W = $clog2(KEPT + 1);

  // input byte register
  logic       byte_valid;
  logic [7:0] byte_q;

  // parser state
  ctp_pkg::mode_t                mode, mode_next;
  logic                          negative_side, negative_side_next;
  logic [1:0]                    deg_seen, deg_seen_next;
  logic [ctp_pkg::DEG_W-1:0]     deg_value, deg_value_next;
  logic [ctp_pkg::FRAC_W-1:0]    frac_scaled, frac_scaled_next;
  logic [CNT_W-1:0]              frac_count, frac_count_next;
  logic                          error_seen, error_seen_next;

  // result register
  logic                          out_valid;
  logic                          out_is_lon;
  logic signed [ctp_pkg::COORD_W-1:0] out_coord;
  logic                          out_bad;

  logic                          is_digit;
  logic [3:0]                    digit;
  logic                          close_now;
  logic                          fire;
  logic [1:0]                    need;
  logic [3:0]                    cnt_ext;
  logic [ctp_pkg::COORD_W-1:0]   mag;
  logic [ctp_pkg::COORD_W-1:0]   coord_next;
  logic                          bad_next;

  // byte decode
  assign is_digit = (byte_q >= ctp_pkg::CHAR_ZERO) && (byte_q <= ctp_pkg::CHAR_NINE);
  assign digit    = is_digit ? 4'(byte_q - ctp_pkg::CHAR_ZERO) : 4'd0;
  assign need     = (mode == ctp_pkg::MODE_LON) ? ctp_pkg::LON_DEG_CHARS
                                                : ctp_pkg::LAT_DEG_CHARS;
  assign cnt_ext  = 4'(frac_count);

  assign close_now = byte_valid &&
    (((mode == ctp_pkg::MODE_LAT) &&
      ((byte_q == ctp_pkg::CHAR_N) || (byte_q == ctp_pkg::CHAR_S))) ||
     ((mode == ctp_pkg::MODE_LON) &&
      ((byte_q == ctp_pkg::CHAR_E) || (byte_q == ctp_pkg::CHAR_W))));

  // a closing byte waits only while the result register is full and stalled
  assign fire     = byte_valid && (!close_now || !out_valid || coord.ready);
  assign rx.ready = !rst && (!byte_valid || fire);

  // input byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx.ready) begin
      byte_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      byte_q <= rx.rx_byte;
    end
  end

  // parser next state
  always_comb begin
    mode_next          = mode;
    negative_side_next = negative_side;
    deg_seen_next      = deg_seen;
    deg_value_next     = deg_value;
    frac_scaled_next   = frac_scaled;
    frac_count_next    = frac_count;
    error_seen_next    = error_seen;
    if (fire) begin
      unique case (mode)
        ctp_pkg::MODE_LAT, ctp_pkg::MODE_LON: begin
          if (close_now) begin
            mode_next = ctp_pkg::MODE_IDLE;
          end else if (deg_seen < need) begin
            // degree position: a non-digit counts as zero and flags an error
            if (!is_digit) begin
              error_seen_next = 1'b1;
            end
            deg_value_next = ctp_pkg::DEG_W'(deg_value * 10'd10 + ctp_pkg::DEG_W'(digit));
            deg_seen_next  = 2'(deg_seen + 2'd1);
          end else if (byte_q == ctp_pkg::CHAR_DOT) begin
            // separator skipped
          end else if (is_digit) begin
            if (int'(frac_count) < KEPT) begin
              frac_count_next = CNT_W'(frac_count + 1'b1);
              if (int'(cnt_ext) < ctp_pkg::MICRO_DIGITS) begin
                frac_scaled_next = ctp_pkg::FRAC_W'(frac_scaled +
                  ctp_pkg::digit_weight(digit, cnt_ext[2:0]));
              end
            end
          end else begin
            error_seen_next = 1'b1;
          end
        end
        default: begin
          // idle: an opening letter starts a field
          if ((byte_q == ctp_pkg::CHAR_N) || (byte_q == ctp_pkg::CHAR_S) ||
              (byte_q == ctp_pkg::CHAR_E) || (byte_q == ctp_pkg::CHAR_W)) begin
            mode_next = ((byte_q == ctp_pkg::CHAR_N) || (byte_q == ctp_pkg::CHAR_S))
                        ? ctp_pkg::MODE_LAT : ctp_pkg::MODE_LON;
            negative_side_next = (byte_q == ctp_pkg::CHAR_S) ||
                                 (byte_q == ctp_pkg::CHAR_W);
            deg_seen_next    = '0;
            deg_value_next   = '0;
            frac_scaled_next = '0;
            frac_count_next  = '0;
            error_seen_next  = 1'b0;
          end
        end
      endcase
    end
  end

  // result value at field close
  always_comb begin
    mag = ctp_pkg::COORD_W'(ctp_pkg::COORD_W'(deg_value) * ctp_pkg::MICRO_SCALE +
                            ctp_pkg::COORD_W'(frac_scaled));
    coord_next = negative_side ? ctp_pkg::COORD_W'(31'd0 - mag) : mag;
    bad_next   = error_seen || (deg_seen < need);
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= ctp_pkg::MODE_IDLE;
      negative_side <= 1'b0;
      deg_seen      <= '0;
      deg_value     <= '0;
      frac_scaled   <= '0;
      frac_count    <= '0;
      error_seen    <= 1'b0;
    end else begin
      mode          <= mode_next;
      negative_side <= negative_side_next;
      deg_seen      <= deg_seen_next;
      deg_value     <= deg_value_next;
      frac_scaled   <= frac_scaled_next;
      frac_count    <= frac_count_next;
      error_seen    <= error_seen_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && close_now) begin
      out_valid <= 1'b1;
    end else if (coord.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && close_now) begin
      out_is_lon <= (mode == ctp_pkg::MODE_LON);
      out_coord  <= coord_next;
      out_bad    <= bad_next;
    end
  end

  assign coord.valid            = out_valid;
  assign coord.is_longitude     = out_is_lon;
  assign coord.coordinate_micro = out_coord;
  assign coord.bad_text         = out_bad;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int FRAC_KEPT    = 6;
  localparam int FIELD_ITEMS  = 1400;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic               is_longitude;
    logic signed [30:0] coordinate_micro;
    logic               bad_text;
  } coord_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       closes;
    coord_t     result;
  } dir_row_t;

  localparam coord_t NO_RESULT = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ctp_byte_if  rx ();
  ctp_coord_if coord ();

  coordinate_text_parser #(.FRAC_DIGITS(FRAC_KEPT)) uut (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .coord (coord)
  );

  always #6 clk = ~clk;

  // directed bytes; a typed result only where a field closes
  dir_row_t directed_rows [26] = '{
    '{8'hFF,             1'b0, NO_RESULT},
    '{ctp_pkg::CHAR_N,   1'b0, NO_RESULT},
    '{"9",               1'b0, NO_RESULT},
    '{"0",               1'b0, NO_RESULT},
    '{ctp_pkg::CHAR_DOT, 1'b0, NO_RESULT},
    '{"1",               1'b0, NO_RESULT},
    '{"2",               1'b0, NO_RESULT},
    '{"3",               1'b0, NO_RESULT},
    '{"4",               1'b0, NO_RESULT},
    '{"5",               1'b0, NO_RESULT},
    '{"6",               1'b0, NO_RESULT},
    '{"7",               1'b0, NO_RESULT},
    '{ctp_pkg::CHAR_N,   1'b1, '{1'b0, 31'sd90123456, 1'b0}},
    '{ctp_pkg::CHAR_S,   1'b0, NO_RESULT},
    '{ctp_pkg::CHAR_DOT, 1'b0, NO_RESULT},
    '{"5",               1'b0, NO_RESULT},
    '{ctp_pkg::CHAR_E,   1'b0, NO_RESULT},
    '{ctp_pkg::CHAR_S,   1'b1, '{1'b0, -31'sd5000000, 1'b1}},
    '{ctp_pkg::CHAR_W,   1'b0, NO_RESULT},
    '{"1",               1'b0, NO_RESULT},
    '{"8",               1'b0, NO_RESULT},
    '{"0",               1'b0, NO_RESULT},
    '{8'h00,             1'b0, NO_RESULT},
    '{ctp_pkg::CHAR_W,   1'b1, '{1'b1, -31'sd180000000, 1'b1}},
    '{ctp_pkg::CHAR_E,   1'b0, NO_RESULT},
    '{ctp_pkg::CHAR_E,   1'b1, '{1'b1, 31'sd0, 1'b1}}
  };

  // parser state mirror
  ctp_pkg::mode_t cur_mode     = ctp_pkg::MODE_IDLE;
  logic           cur_negative = 1'b0;
  int unsigned    deg_chars    = 0;
  int unsigned    frac_digits  = 0;
  logic [31:0]    deg_acc      = '0;
  logic [31:0]    frac_acc     = '0;
  logic           text_bad     = 1'b0;

  coord_t      pending_coords [$];
  int unsigned field_items = 0;
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  logic        src_calm    = 1'b0;
  logic        hold_go     = 1'b0;

  // advance the parser by one byte; returns 1 when a field closes
  function automatic logic parse_char(input logic [7:0] b, output coord_t res);
    logic        is_digit;
    logic [31:0] dv;
    logic [31:0] scaled;
    logic [31:0] mag;
    int unsigned need;
    int unsigned kept;
    int unsigned n;
    is_digit = (b >= ctp_pkg::CHAR_ZERO) && (b <= ctp_pkg::CHAR_NINE);
    dv = is_digit ? 32'(b - ctp_pkg::CHAR_ZERO) : 32'd0;
    need = (cur_mode == ctp_pkg::MODE_LON) ? 32'(ctp_pkg::LON_DEG_CHARS)
                                           : 32'(ctp_pkg::LAT_DEG_CHARS);
    kept = (FRAC_KEPT > 9) ? 9 : FRAC_KEPT;
    res = NO_RESULT;

    // closing letter of the open field
    if ((cur_mode == ctp_pkg::MODE_LAT && (b == ctp_pkg::CHAR_N || b == ctp_pkg::CHAR_S)) ||
        (cur_mode == ctp_pkg::MODE_LON && (b == ctp_pkg::CHAR_E || b == ctp_pkg::CHAR_W)))
    begin
      if (deg_chars < need) text_bad = 1'b1;
      scaled = frac_acc;
      for (n = frac_digits; n < ctp_pkg::MICRO_DIGITS; n++) scaled = scaled * 32'd10;
      for (n = frac_digits; n > ctp_pkg::MICRO_DIGITS; n--) scaled = scaled / 32'd10;
      mag = deg_acc * 32'd1000000 + scaled;
      if (cur_negative) mag = -mag;
      res.is_longitude     = (cur_mode == ctp_pkg::MODE_LON);
      res.coordinate_micro = mag[30:0];
      res.bad_text         = text_bad;
      cur_mode = ctp_pkg::MODE_IDLE;
      return 1'b1;
    end

    // idle: only a hemisphere letter opens a field
    if (cur_mode == ctp_pkg::MODE_IDLE) begin
      if (b == ctp_pkg::CHAR_N || b == ctp_pkg::CHAR_S ||
          b == ctp_pkg::CHAR_E || b == ctp_pkg::CHAR_W) begin
        cur_mode     = (b == ctp_pkg::CHAR_N || b == ctp_pkg::CHAR_S) ? ctp_pkg::MODE_LAT
                                                                      : ctp_pkg::MODE_LON;
        cur_negative = (b == ctp_pkg::CHAR_S || b == ctp_pkg::CHAR_W);
        deg_chars    = 0;
        frac_digits  = 0;
        deg_acc      = '0;
        frac_acc     = '0;
        text_bad     = 1'b0;
      end
      return 1'b0;
    end

    // degree digits, then separator and fraction
    if (deg_chars < need) begin
      if (!is_digit) text_bad = 1'b1;
      deg_acc = deg_acc * 32'd10 + dv;
      deg_chars++;
    end else if (b == ctp_pkg::CHAR_DOT) begin
      // separator skipped
    end else if (is_digit) begin
      if (frac_digits < kept) begin
        frac_acc = frac_acc * 32'd10 + dv;
        frac_digits++;
      end
    end else begin
      text_bad = 1'b1;
    end
    return 1'b0;
  endfunction

  // mostly back to back, sometimes a short gap, rarely a long gap
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] rand_digit();
    return ctp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // offer one byte and record what its transfer should produce
  task automatic send_byte(input logic [7:0] b, input logic typed, input coord_t want);
    coord_t      pred;
    logic        fired;
    int unsigned gap;
    gap = src_calm ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      rx.valid <= 1'b0;
    end
    @(negedge clk);
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
    fired = parse_char(b, pred);
    if (typed) pending_coords.push_back(want);
    else if (fired) pending_coords.push_back(pred);
  endtask

  task automatic feed(input logic [7:0] b);
    send_byte(b, 1'b0, NO_RESULT);
    field_items++;
  endtask

  // one field with random content, occasionally malformed
  task automatic send_field();
    logic        lon;
    logic        nines;
    logic [7:0]  b;
    int unsigned deg_len;
    int unsigned frac_len;
    int unsigned r;
    lon   = 1'($urandom_range(0, 1));
    nines = ($urandom_range(0, 29) == 0);
    deg_len = lon ? 32'(ctp_pkg::LON_DEG_CHARS) : 32'(ctp_pkg::LAT_DEG_CHARS);
    if ($urandom_range(0, 9) == 0) deg_len = $urandom_range(0, deg_len - 1);

    if (lon) feed($urandom_range(0, 1) ? ctp_pkg::CHAR_W : ctp_pkg::CHAR_E);
    else feed($urandom_range(0, 1) ? ctp_pkg::CHAR_S : ctp_pkg::CHAR_N);

    repeat (deg_len) begin
      r = $urandom_range(0, 19);
      b = nines ? ctp_pkg::CHAR_NINE : rand_digit();
      if (r == 0) b = ctp_pkg::CHAR_DOT;
      else if (r == 1) b = 8'($urandom_range(0, 255));
      feed(b);
    end

    if ($urandom_range(0, 4) != 0) feed(ctp_pkg::CHAR_DOT);
    frac_len = $urandom_range(0, 9);
    repeat (frac_len) begin
      b = nines ? ctp_pkg::CHAR_NINE : rand_digit();
      if ($urandom_range(0, 24) == 0) b = 8'($urandom_range(0, 255));
      feed(b);
    end

    if (lon) feed($urandom_range(0, 1) ? ctp_pkg::CHAR_W : ctp_pkg::CHAR_E);
    else feed($urandom_range(0, 1) ? ctp_pkg::CHAR_S : ctp_pkg::CHAR_N);
  endtask

  // stop offering and wait for every expected coordinate
  task automatic drain();
    @(negedge clk);
    rx.valid <= 1'b0;
    while (pending_coords.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin : stimulus
    logic hold_done;
    logic pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    rx.valid   <= 1'b0;
    rx.rx_byte <= 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k])
      send_byte(directed_rows[k].rx_byte, directed_rows[k].closes, directed_rows[k].result);
    drain();

    while (field_items < FIELD_ITEMS) begin
      src_calm = ($urandom_range(0, 5) == 0);
      // long receiver hold-off while fields keep coming back to back
      if (!hold_done && field_items >= 400) begin
        hold_done = 1'b1;
        hold_go   = 1'b1;
        src_calm  = 1'b1;
        repeat (30) send_field();
        src_calm  = 1'b0;
      end
      if (!pause_done && field_items >= 900) begin
        pause_done = 1'b1;
        drain();
      end
      // stray bytes between fields
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
      send_field();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("coordinate_text_parser regression: pass");
    end else begin
      $display("coordinate_text_parser regression: fail");
    end
    $finish;
  end

  // result side ready pattern
  initial begin : result_sink
    int unsigned stall;
    int unsigned hold_left;
    int unsigned calm_left;
    stall     = 0;
    hold_left = 0;
    calm_left = 0;
    coord.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(50, 150);
      if (hold_left > 0) begin
        hold_left--;
        coord.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        coord.ready <= 1'b0;
      end else begin
        coord.ready <= 1'b1;
        stall = (calm_left > 0) ? 0 : pick_gap();
      end
    end
  end

  // compare each coordinate transfer with the oldest expectation
  always @(posedge clk) begin : check_coord
    coord_t want;
    if (!rst && coord.valid && coord.ready) begin
      if (pending_coords.size() == 0) begin
        $display("%0t: unexpected coordinate lon=%0b coord=%0d bad=%0b", $time,
                 coord.is_longitude, coord.coordinate_micro, coord.bad_text);
        mismatches++;
      end else begin
        want = pending_coords.pop_front();
        if (coord.is_longitude !== want.is_longitude) begin
          $display("%0t: is_longitude expected %0b got %0b", $time,
                   want.is_longitude, coord.is_longitude);
          mismatches++;
        end
        if (coord.coordinate_micro !== want.coordinate_micro) begin
          $display("%0t: coordinate_micro expected %0d got %0d", $time,
                   want.coordinate_micro, coord.coordinate_micro);
          mismatches++;
        end
        if (coord.bad_text !== want.bad_text) begin
          $display("%0t: bad_text expected %0b got %0b", $time,
                   want.bad_text, coord.bad_text);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (rx.valid && rx.ready) || (coord.valid && coord.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("coordinate_text_parser regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
